// ----- hdl/key_value_config_parser_defines.svh -----
// Assertion macros for the checker file of the configuration text parser.
// Needs a clock named clk and a synchronous reset named rst in the scope of use.
`ifndef KEY_VALUE_CONFIG_PARSER_DEFINES_SVH
`define KEY_VALUE_CONFIG_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KVCP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kvcp assertion failed");

// Next-cycle implication, checked outside reset.
`define KVCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kvcp assertion failed");

`endif

// ----- hdl/kvcp_pkg.sv -----
// Package for the configuration text parser: widths, character codes, key spellings,
// the result struct and key match helpers. No dependencies.
`timescale 1ns / 1ps

package kvcp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int WIDE_W     = VALUE_BITS + 4;
  localparam int OUT_W      = 32;
  localparam int COUNT_W    = 16;
  localparam int KLEN_W     = 4;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
  localparam logic [COUNT_W-1:0]    COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [KLEN_W-1:0]     KLEN_MAX  = {KLEN_W{1'b1}};

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [KLEN_W-1:0] BAUD_LEN  = 4'd4;
  localparam logic [KLEN_W-1:0] RETRY_LEN = 4'd7;
  localparam logic [KLEN_W-1:0] ECHO_LEN  = 4'd4;

  // "baud", "retries", "echo"
  localparam logic [7:0] KEY_BAUD  [4] = '{8'h62, 8'h61, 8'h75, 8'h64};
  localparam logic [7:0] KEY_RETRY [7] = '{8'h72, 8'h65, 8'h74, 8'h72, 8'h69, 8'h65, 8'h73};
  localparam logic [7:0] KEY_ECHO  [4] = '{8'h65, 8'h63, 8'h68, 8'h6F};

  typedef struct packed {
    logic [OUT_W-1:0]   baud;
    logic [OUT_W-1:0]   retry;
    logic               echo;
    logic [COUNT_W-1:0] pairs;
  } kvcp_result_t;

  function automatic logic match_baud(logic [KLEN_W-1:0] len, logic [7:0] c);
    return (len < BAUD_LEN) && (KEY_BAUD[len[1:0]] == c);
  endfunction

  function automatic logic match_retry(logic [KLEN_W-1:0] len, logic [7:0] c);
    return (len < RETRY_LEN) && (KEY_RETRY[len[2:0]] == c);
  endfunction

  function automatic logic match_echo(logic [KLEN_W-1:0] len, logic [7:0] c);
    return (len < ECHO_LEN) && (KEY_ECHO[len[1:0]] == c);
  endfunction

endpackage

// ----- hdl/key_value_config_parser.sv -----
// Channel   Direction  Handshake           Payload
// in        sink       in_valid/in_stall   char_code
// out       source     out_valid/out_stall baud_value, retry_value, echo_on, pairs_seen
//
// One byte per cycle unless a result is stalled: each byte sits in the input register,
// where the parser state update runs, and a zero byte loads the result register from
// the input register in the same step as that update.
// Only a zero byte can wait: it holds the input register while a result is stalled.
// Synchronous reset returns the parser to the key phase and clears all settings.
// Top level of the configuration text parser; depends on kvcp_pkg and kvcp_core.
`timescale 1ns / 1ps

module key_value_config_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    char_code,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kvcp_pkg::OUT_W-1:0]    baud_value,
  output logic [kvcp_pkg::OUT_W-1:0]    retry_value,
  output logic                          echo_on,
  output logic [kvcp_pkg::COUNT_W-1:0]  pairs_seen
);
  import kvcp_pkg::*;

  logic         stage_valid;
  logic [7:0]   stage_char;
  logic         stage_end;
  logic         advance;
  logic         out_free;
  kvcp_result_t result;

  assign stage_end = (stage_char == CH_NUL);
  assign out_free  = !out_valid || !out_stall;
  assign advance   = stage_valid && (!stage_end || out_free);
  assign in_stall  = stage_valid && !advance;

  kvcp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .char_code (stage_char),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage_char <= char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && stage_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_end) begin
      baud_value  <= result.baud;
      retry_value <= result.retry;
      echo_on     <= result.echo;
      pairs_seen  <= result.pairs;
    end
  end

endmodule

// ----- hdl/kvcp_core.sv -----
// Parser state and per-byte update of the configuration text parser.
// Depends on kvcp_pkg. Updates its state on each step and shows the result of that byte.
`timescale 1ns / 1ps

module kvcp_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            char_code,
  output kvcp_pkg::kvcp_result_t result
);
  import kvcp_pkg::*;

  localparam logic [1:0] PH_KEY   = 2'd0;
  localparam logic [1:0] PH_VALUE = 2'd1;
  localparam logic [1:0] PH_SKIP  = 2'd2;

  logic [1:0]            phase, phase_next;
  logic [KLEN_W-1:0]     key_length, key_length_next;
  logic [2:0]            match_flags, match_flags_next;
  logic [VALUE_BITS-1:0] number_acc, number_acc_next;
  logic [COUNT_W-1:0]    frag_count, frag_count_next;
  logic [VALUE_BITS-1:0] baud_store, baud_store_next;
  logic [VALUE_BITS-1:0] retry_store, retry_store_next;
  logic                  echo_store, echo_store_next;

  logic                  is_digit;
  logic [3:0]            digit;
  logic [WIDE_W-1:0]     times_ten;
  logic                  finish;
  logic [2:0]            keep;

  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign digit    = 4'(char_code - CH_ZERO);
  // acc * 10 + digit as shift-add; any bit above the value width means saturation.
  assign times_ten = (WIDE_W'(number_acc) << 3) + (WIDE_W'(number_acc) << 1)
                   + WIDE_W'(digit);
  assign keep = {match_echo(key_length, char_code), match_retry(key_length, char_code),
                 match_baud(key_length, char_code)};

  always_comb begin
    phase_next       = phase;
    key_length_next  = key_length;
    match_flags_next = match_flags;
    number_acc_next  = number_acc;
    frag_count_next  = frag_count;
    baud_store_next  = baud_store;
    retry_store_next = retry_store;
    echo_store_next  = echo_store;
    finish           = 1'b0;

    unique case (phase)
      PH_KEY: begin
        if (char_code == CH_SEMI) begin
          key_length_next  = '0;
          match_flags_next = 3'b111;
        end else if (char_code == CH_EQ) begin
          phase_next      = PH_VALUE;
          number_acc_next = '0;
        end else if (char_code != CH_NUL) begin
          match_flags_next = match_flags & keep;
          if (key_length != KLEN_MAX) begin
            key_length_next = key_length + 1'b1;
          end
        end
      end
      PH_VALUE: begin
        if (is_digit) begin
          if (|times_ten[WIDE_W-1:VALUE_BITS]) begin
            number_acc_next = VALUE_MAX;
          end else begin
            number_acc_next = times_ten[VALUE_BITS-1:0];
          end
        end else begin
          finish = 1'b1;
          if (char_code == CH_SEMI) begin
            phase_next       = PH_KEY;
            key_length_next  = '0;
            match_flags_next = 3'b111;
          end else if (char_code != CH_NUL) begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (char_code == CH_SEMI) begin
          phase_next       = PH_KEY;
          key_length_next  = '0;
          match_flags_next = 3'b111;
        end
      end
      default: begin
        phase_next = PH_KEY;
      end
    endcase

    // A value ends: store it under the key that matched and count the fragment.
    if (finish) begin
      if (match_flags[0] && (key_length == BAUD_LEN)) begin
        baud_store_next = number_acc;
      end else if (match_flags[1] && (key_length == RETRY_LEN)) begin
        retry_store_next = number_acc;
      end else if (match_flags[2] && (key_length == ECHO_LEN)) begin
        echo_store_next = |number_acc;
      end
      if (frag_count != COUNT_MAX) begin
        frag_count_next = frag_count + 1'b1;
      end
    end

    result.baud  = OUT_W'(baud_store_next);
    result.retry = OUT_W'(retry_store_next);
    result.echo  = echo_store_next;
    result.pairs = frag_count_next;

    // The end of the text starts a fresh one.
    if (char_code == CH_NUL) begin
      phase_next       = PH_KEY;
      key_length_next  = '0;
      match_flags_next = 3'b111;
      number_acc_next  = '0;
      frag_count_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_KEY;
      key_length  <= '0;
      match_flags <= 3'b111;
      number_acc  <= '0;
      frag_count  <= '0;
      baud_store  <= '0;
      retry_store <= '0;
      echo_store  <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      key_length  <= key_length_next;
      match_flags <= match_flags_next;
      number_acc  <= number_acc_next;
      frag_count  <= frag_count_next;
      baud_store  <= baud_store_next;
      retry_store <= retry_store_next;
      echo_store  <= echo_store_next;
    end
  end

endmodule

// ----- hdl/kvcp_checker.sv -----
// Port-level checks for the configuration text parser, bound to its top level.
// Depends on kvcp_pkg and the assertion macros in key_value_config_parser_defines.svh.
`timescale 1ns / 1ps
`include "key_value_config_parser_defines.svh"

module kvcp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [7:0]                    char_code,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [kvcp_pkg::OUT_W-1:0]    baud_value,
  input logic [kvcp_pkg::OUT_W-1:0]    retry_value,
  input logic                          echo_on,
  input logic [kvcp_pkg::COUNT_W-1:0]  pairs_seen
);
  import kvcp_pkg::*;

  // A result that waits stays offered.
  `KVCP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // A waiting result does not change.
  `KVCP_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
    $stable(baud_value) && $stable(retry_value) && $stable(echo_on) && $stable(pairs_seen))

  // The input only waits behind a stalled result.
  `KVCP_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)

  // A fresh result comes from an accepted end-of-text byte that has passed through the input register.
  `KVCP_ASSERT_IMPL(a_result_source, $rose(out_valid),
    $past(in_valid && !in_stall && (char_code == CH_NUL), 2))

endmodule

bind key_value_config_parser kvcp_checker u_kvcp_checker (.*);

// ----- test/key_value_config_parser_test.sv -----
// Self-checking testbench for key_value_config_parser: it parses the same text in a
// behavioral predictor and compares every reported settings item. Depends on kvcp_pkg.
`timescale 1ns / 1ps

module key_value_config_parser_test;
  import kvcp_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int SETTLE_TICKS = 8;
  localparam int RANDOM_BYTES = 1300;

  typedef enum logic [1:0] {SCAN_KEY, SCAN_VALUE, SCAN_SKIP} scan_phase_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           char_code = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUT_W-1:0]     baud_value;
  logic [OUT_W-1:0]     retry_value;
  logic                 echo_on;
  logic [COUNT_W-1:0]   pairs_seen;

  // Predictor state, mirroring what the parser should hold.
  scan_phase_t          text_phase = SCAN_KEY;
  logic [KLEN_W-1:0]    key_len = '0;
  logic [2:0]           key_hits = 3'b111;
  logic [VALUE_BITS-1:0] value_acc = '0;
  logic [COUNT_W-1:0]   frag_count = '0;
  logic [VALUE_BITS-1:0] baud_setting = '0;
  logic [VALUE_BITS-1:0] retry_setting = '0;
  logic                 echo_setting = 1'b0;

  kvcp_result_t         pending_reports[$];
  int                   errors = 0;
  int                   bytes_sent = 0;
  int                   cycle_count = 0;
  bit                   idle_on = 1'b0;
  int                   hold_left = 0;
  int                   stall_left = 0;

  key_value_config_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_code(char_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .baud_value(baud_value),
    .retry_value(retry_value),
    .echo_on(echo_on),
    .pairs_seen(pairs_seen)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void restart_key();
    text_phase = SCAN_KEY;
    key_len = '0;
    key_hits = 3'b111;
  endfunction

  function automatic void close_value();
    if (key_hits[0] && key_len == BAUD_LEN) begin
      baud_setting = value_acc;
    end else if (key_hits[1] && key_len == RETRY_LEN) begin
      retry_setting = value_acc;
    end else if (key_hits[2] && key_len == ECHO_LEN) begin
      echo_setting = (value_acc != '0);
    end
    if (frag_count != COUNT_MAX) begin
      frag_count = frag_count + 1'b1;
    end
  endfunction

  // Advances the predicted parser by one byte; returns 1 when a report is due.
  function automatic bit parse_char(input logic [7:0] c, output kvcp_result_t rep);
    logic [VALUE_BITS-1:0] digit;
    logic [2:0]            keep;
    rep = '0;
    case (text_phase)
      SCAN_KEY: begin
        if (c == CH_SEMI) begin
          restart_key();
        end else if (c == CH_EQ) begin
          text_phase = SCAN_VALUE;
          value_acc = '0;
        end else if (c != CH_NUL) begin
          keep[0] = (key_len < BAUD_LEN) && (KEY_BAUD[key_len[1:0]] == c);
          keep[1] = (key_len < RETRY_LEN) && (KEY_RETRY[key_len[2:0]] == c);
          keep[2] = (key_len < ECHO_LEN) && (KEY_ECHO[key_len[1:0]] == c);
          key_hits = key_hits & keep;
          if (key_len != KLEN_MAX) begin
            key_len = key_len + 1'b1;
          end
        end
      end
      SCAN_VALUE: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          digit = VALUE_BITS'(c - CH_ZERO);
          if (value_acc > (VALUE_MAX - digit) / 10) begin
            value_acc = VALUE_MAX;
          end else begin
            value_acc = value_acc * 10 + digit;
          end
        end else begin
          close_value();
          if (c == CH_SEMI) begin
            restart_key();
          end else if (c != CH_NUL) begin
            text_phase = SCAN_SKIP;
          end
        end
      end
      default: begin
        if (c == CH_SEMI) begin
          restart_key();
        end
      end
    endcase
    if (c == CH_NUL) begin
      rep.baud  = baud_setting[OUT_W-1:0];
      rep.retry = retry_setting[OUT_W-1:0];
      rep.echo  = echo_setting;
      rep.pairs = frag_count;
      frag_count = '0;
      value_acc = '0;
      restart_key();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offers one byte, with an optional idle gap before it, and waits until it is taken.
  task automatic send_char(input logic [7:0] c);
    int           gap;
    kvcp_result_t rep;
    gap = 0;
    if (idle_on && $urandom_range(0, 99) >= 60) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (parse_char(c, rep)) begin
      pending_reports.push_back(rep);
    end
  endtask

  task automatic send_text(input string s, input bit terminate = 1'b1);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
    if (terminate) begin
      send_char(CH_NUL);
    end
  endtask

  task automatic wait_all_reported();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Receiver side: random stalls, plus a long hold-off when a test requests one.
  always @(negedge clk) begin
    logic s;
    if (hold_left > 0) begin
      s = 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      s = 1'b1;
      stall_left--;
    end else begin
      s = 1'b0;
      if (idle_on && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      end
    end
    out_stall <= s;
  end

  always @(posedge clk) begin
    kvcp_result_t want;
    kvcp_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.baud  = baud_value;
      got.retry = retry_value;
      got.echo  = echo_on;
      got.pairs = pairs_seen;
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected item: baud=%0d retries=%0d echo=%0d pairs=%0d",
                   got.baud, got.retry, got.echo, got.pairs);
        end
      end else begin
        want = pending_reports.pop_front();
        if (got.baud !== want.baud || got.retry !== want.retry ||
            got.echo !== want.echo || got.pairs !== want.pairs) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected baud=%0d retries=%0d echo=%0d pairs=%0d",
                     want.baud, want.retry, want.echo, want.pairs);
            $display("          actual   baud=%0d retries=%0d echo=%0d pairs=%0d",
                     got.baud, got.retry, got.echo, got.pairs);
          end
        end
      end
    end
  end

  task automatic test_known_keys();
    idle_on = 1'b1;
    send_text("");
    send_text("baud=115200;retries=3;echo=1");
    send_text("echo=00;retries=0007x9");
    wait_all_reported();
  endtask

  task automatic test_partial_fragments();
    // Empty value, junk after digits, and a text that ends inside a key.
    send_text("baud=;echo=5z;;tail");
    send_text("retries=12");
    wait_all_reported();
  endtask

  task automatic test_value_overflow();
    send_text("retries=99999999999;baud=4294967295");
    send_text("baud=4294967296;echo=");
    wait_all_reported();
  endtask

  task automatic test_unmatched_keys();
    // Untrimmed, truncated, extended, case-shifted and overlong keys never match.
    send_text(" baud=7;baudx=8;bau=9;Baud=3;echoecho=1;retriesretriesretries=5;=;a=b=c");
    send_char(8'hFF);
    send_char(8'h80);
    send_text("=9;echo=", 1'b0);
    send_char(8'hB9);
    send_char(CH_NUL);
    wait_all_reported();
  endtask

  task automatic test_output_hold();
    idle_on = 1'b0;
    hold_left = 300;
    for (int i = 0; i < 6; i++) begin
      send_text((i % 2 == 0) ? "echo=1;baud=42" : "echo=0;retries=9");
    end
    wait_all_reported();
  endtask

  task automatic send_random_text();
    int    frags;
    int    kind;
    int    digits;
    int    idx;
    string key;
    frags = $urandom_range(0, 6);
    for (int f = 0; f < frags; f++) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        case ($urandom_range(0, 4))
          0: key = "baud";
          1: key = "retries";
          2: key = "echo";
          3: begin
            key = ($urandom_range(0, 1) != 0) ? "baud" : "retries";
            idx = $urandom_range(0, key.len() - 1);
            key[idx] = 8'($urandom_range(8'h61, 8'h7A));
          end
          default: key = "";
        endcase
        if (key.len() == 0) begin
          repeat ($urandom_range(1, 17)) send_char(8'($urandom_range(8'h61, 8'h7A)));
        end else begin
          send_text(key, 1'b0);
        end
        send_char(CH_EQ);
        digits = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
        repeat (digits) send_char(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(1, 255)));
        end
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(8'h61, 8'h7A)));
      end
      if (f != frags - 1 || $urandom_range(0, 1) != 0) begin
        send_char(CH_SEMI);
      end
    end
    send_char(CH_NUL);
  endtask

  task automatic test_random_texts();
    int start;
    int texts;
    start = bytes_sent;
    texts = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      // Every third block of texts runs with no idling on either side.
      if (texts % 20 == 0) begin
        idle_on = ((texts / 20) % 3 != 2);
      end
      send_random_text();
      texts++;
    end
    wait_all_reported();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_known_keys();
    test_partial_fragments();
    test_value_overflow();
    test_unmatched_keys();
    test_output_hold();
    test_random_texts();
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
